// ----- rtl/core/mtg_pkg.sv -----
`timescale 1ns / 1ps

package mtg_pkg;

  localparam int STATE_DEPTH  = 624;
  localparam int TWIST_OFFSET = 397;
  localparam int IDX_W        = $clog2(STATE_DEPTH);

  typedef logic [31:0]      word_t;
  typedef logic [IDX_W-1:0] idx_t;

  localparam idx_t  LAST_IDX  = idx_t'(STATE_DEPTH - 1);
  localparam word_t SEED_RST  = 32'd5489;
  localparam word_t MT_MATRIX = 32'h9908_b0df;
  localparam word_t MT_MULT   = 32'd1812433253;
  localparam word_t TEMPER_B  = 32'h9d2c_5680;
  localparam word_t TEMPER_C  = 32'hefc6_0000;

  // One write port request into the state memory.
  typedef struct packed {
    logic  en;
    idx_t  addr;
    word_t data;
  } mem_wr_t;

  // Two-address read request; the data comes back registered, in the cycle after the request.
  typedef struct packed {
    logic en;
    idx_t addr_a;
    idx_t addr_b;
  } mem_rd_t;

endpackage

// ----- rtl/core/mtg_state_mem.sv -----
`timescale 1ns / 1ps

module mtg_state_mem (
  input  logic            clk,
  input  mtg_pkg::mem_wr_t wr,
  input  mtg_pkg::mem_rd_t rd,
  output mtg_pkg::word_t  rd_data_a,
  output mtg_pkg::word_t  rd_data_b
);
  import mtg_pkg::*;

  word_t mem [STATE_DEPTH];
  word_t rd_data_a_r;
  word_t rd_data_b_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Read data is registered and held until the next read request.
  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data_a_r <= mem[rd.addr_a];
      rd_data_b_r <= mem[rd.addr_b];
    end
  end

  assign rd_data_a = rd_data_a_r;
  assign rd_data_b = rd_data_b_r;

endmodule

// ----- rtl/core/mtg_seeder.sv -----
`timescale 1ns / 1ps

module mtg_seeder (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  mtg_pkg::word_t   seed,
  output mtg_pkg::mem_wr_t wr,
  output logic             last
);
  import mtg_pkg::*;

  logic  busy_r;
  idx_t  cnt_r;
  word_t prev_r;
  word_t fill_word;

  // One word of the initialization recurrence from the previous word.
  function automatic word_t seed_step(input word_t prev, input idx_t k);
    word_t x;
    x = prev ^ (prev >> 30);
    return x * MT_MULT + {{(32-IDX_W){1'b0}}, k};
  endfunction

  assign fill_word = (cnt_r == '0) ? seed : seed_step(prev_r, cnt_r);
  assign wr.en     = busy_r;
  assign wr.addr   = cnt_r;
  assign wr.data   = fill_word;
  assign last      = busy_r && (cnt_r == LAST_IDX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      if (cnt_r == LAST_IDX) begin
        busy_r <= 1'b0;
      end
      cnt_r <= cnt_r + idx_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      prev_r <= fill_word;
    end
  end

endmodule

// ----- rtl/core/mtg_out_skid.sv -----
`timescale 1ns / 1ps

module mtg_out_skid (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  mtg_pkg::word_t push_data,
  output logic           avail,
  output logic           out_valid,
  input  logic           out_ready,
  output mtg_pkg::word_t out_data
);
  import mtg_pkg::*;

  logic  out_valid_r;
  word_t out_data_r;
  logic  skid_valid_r;
  word_t skid_data_r;

  // The producer only pushes while the skid stage is empty.
  assign avail     = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ready) begin
      out_data_r <= skid_valid_r ? skid_data_r : push_data;
    end else if (push) begin
      skid_data_r <= push_data;
    end
  end

endmodule

// ----- rtl/core/mersenne_twister_generator.sv -----
`timescale 1ns / 1ps

// 32-bit MT19937 random word generator.
// Input channel (in_valid/in_ready/in_half_width): each transfer is one draw
// request. The result channel (out_valid/out_ready/out_random_value) returns
// one tempered word per request, shifted right by one when in_half_width is
// set. Results are registered in the output stage, or in the skid stage on a
// stall, and come out in request order.
// Throughput is one draw per cycle unless a refill runs or the skid stage is
// full. Each draw twists one state word in place, reading the next and the far
// word early from the two state memory read ports, so these set the rate.
// Configuration (cfg_valid/cfg_ready/cfg_seed_value) sets the seed; cfg_ready
// is always high. After reset, and after every seed transfer, the state is
// refilled from the seed, one word per cycle through the seed multiplier,
// and in_ready stays low during the refill.
// When the receiver stalls, one more result is held in the skid stage and
// in_ready drops until it empties. Nothing is lost or repeated.
module mersenne_twister_generator (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           in_half_width,
  output logic           out_valid,
  input  logic           out_ready,
  output mtg_pkg::word_t out_random_value,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  mtg_pkg::word_t cfg_seed_value
);
  import mtg_pkg::*;

  localparam logic ST_SEED = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic    state_r;
  logic    state_nxt;
  idx_t    idx_r;
  idx_t    idx_nxt;
  word_t   seed_r;
  word_t   cur_r;
  word_t   cur_nxt;

  mem_wr_t seed_wr;
  logic    seed_last;
  mem_wr_t mem_wr;
  mem_rd_t mem_rd;
  word_t   rd_next;
  word_t   rd_far;

  logic    accept;
  logic    skid_avail;
  idx_t    pre_next;
  idx_t    pre_far;
  logic [IDX_W:0] far_sum;
  word_t   twisted;
  word_t   tempered;
  word_t   result;

  // Twist of one state word: top bit of the current word, low bits of the
  // following word, folded into the word TWIST_OFFSET ahead.
  function automatic word_t twist_word(input word_t cur, input word_t nxt,
                                       input word_t far);
    word_t y;
    y = {cur[31], nxt[30:0]};
    return far ^ (y >> 1) ^ (y[0] ? MT_MATRIX : '0);
  endfunction

  function automatic word_t temper(input word_t w);
    word_t y;
    y = w;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign in_ready  = (state_r == ST_RUN) && skid_avail;

  // The word just twisted is written back and tempered for the output.
  assign twisted  = twist_word(cur_r, rd_next, rd_far);
  assign tempered = temper(twisted);
  assign result   = in_half_width ? (tempered >> 1) : tempered;

  // Index of the word the next draw will twist, and its prefetch addresses.
  always_comb begin
    unique case (state_r)
      ST_SEED: idx_nxt = '0;
      ST_RUN:  idx_nxt = (idx_r == LAST_IDX) ? '0 : idx_r + idx_t'(1);
      default: idx_nxt = '0;
    endcase
  end

  assign pre_next = (idx_nxt == LAST_IDX) ? '0 : idx_nxt + idx_t'(1);
  assign far_sum  = {1'b0, idx_nxt} + (IDX_W+1)'(TWIST_OFFSET);
  assign pre_far  = (far_sum >= (IDX_W+1)'(STATE_DEPTH))
                  ? idx_t'(far_sum - (IDX_W+1)'(STATE_DEPTH))
                  : idx_t'(far_sum);

  always_comb begin
    state_nxt = state_r;
    cur_nxt   = cur_r;
    mem_wr    = '0;
    mem_rd    = '0;
    unique case (state_r)
      ST_SEED: begin
        mem_wr = seed_wr;
        if (seed_last) begin
          // Word 0 is the seed itself; prefetch words 1 and TWIST_OFFSET.
          state_nxt     = ST_RUN;
          cur_nxt       = seed_r;
          mem_rd.en     = 1'b1;
          mem_rd.addr_a = pre_next;
          mem_rd.addr_b = pre_far;
        end
      end
      ST_RUN: begin
        if (accept) begin
          mem_wr.en     = 1'b1;
          mem_wr.addr   = idx_r;
          mem_wr.data   = twisted;
          cur_nxt       = rd_next;
          mem_rd.en     = 1'b1;
          mem_rd.addr_a = pre_next;
          mem_rd.addr_b = pre_far;
        end
      end
      default: state_nxt = ST_SEED;
    endcase
    if (cfg_valid) begin
      state_nxt = ST_SEED;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_SEED;
      idx_r   <= '0;
      seed_r  <= SEED_RST;
    end else begin
      state_r <= state_nxt;
      if (seed_last || accept) begin
        idx_r <= idx_nxt;
      end
      if (cfg_valid) begin
        seed_r <= cfg_seed_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  mtg_seeder u_seeder (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cfg_valid),
    .seed  (seed_r),
    .wr    (seed_wr),
    .last  (seed_last)
  );

  mtg_state_mem u_mem (
    .clk       (clk),
    .wr        (mem_wr),
    .rd        (mem_rd),
    .rd_data_a (rd_next),
    .rd_data_b (rd_far)
  );

  mtg_out_skid u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (result),
    .avail     (skid_avail),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_random_value)
  );

  // A prefetch never reads the entry being written in the same cycle.
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_rd.en && mem_wr.en) |-> (mem_rd.addr_a != mem_wr.addr &&
                                  mem_rd.addr_b != mem_wr.addr))
    else $error("state memory read and write hit the same entry");

  // A seed transfer blocks draws until the refill is done.
  a_cfg_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |=> !in_ready)
    else $error("draw accepted right after a seed transfer");

  // After every accepted draw, out_valid is high in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("accepted draw produced no result");

  // The end of the refill starts drawing at word 0.
  a_seed_to_run: assert property (@(posedge clk) disable iff (!rst_n)
    (seed_last && !cfg_valid) |=> (state_r == ST_RUN && idx_r == '0))
    else $error("refill did not hand over at word 0");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (idx_r <= LAST_IDX))
    else $error("state index out of range");

endmodule

// ----- bench/mersenne_twister_generator_tb.sv -----
`timescale 1ns / 1ps

// Self-checking bench for the MT19937 draw engine. Every draw request that
// completes a transfer on the input channel is run through a software copy of
// the generator, and the predicted or typed-in word is queued. Every transfer
// on the result channel is compared against the oldest queued word.
module mersenne_twister_generator_tb;
  import mtg_pkg::*;

  // Masks that split a state word into its top bit and the rest.
  localparam word_t WORD_TOP_BIT  = 32'h8000_0000;
  localparam word_t WORD_LOW_BITS = 32'h7fff_ffff;

  // Marker for a state that must be filled from the seed before use.
  localparam int unsigned UNSEEDED = STATE_DEPTH + 1;

  // Receiver hold-off long enough to fill the skid stage and stall the input.
  localparam int HOLD_CYCLES = 100;

  // Worst case is far below this: about 900 draws with idle bursts on both
  // sides, one long hold-off, and a full state refill after reset and after
  // each seed write.
  localparam int CYCLE_LIMIT = 200000;

  localparam int SCRIPT_LEN = 21;

  // One row of the directed script. A reseed row writes the seed register and
  // draws nothing. A draw row with known set carries its result typed in.
  typedef struct packed {
    logic  reseed;
    word_t seed;
    logic  half;
    logic  known;
    word_t value;
  } script_row_t;

  logic  clk;
  logic  rst_n;
  logic  in_valid;
  logic  in_ready;
  logic  in_half_width;
  logic  out_valid;
  logic  out_ready;
  word_t out_random_value;
  logic  cfg_valid;
  logic  cfg_ready;
  word_t cfg_seed_value;

  // Software copy of the generator: seed register, state words and the
  // position of the next word to read.
  word_t       seed_word;
  word_t       twister_words [STATE_DEPTH];
  int unsigned draw_pos;

  // Words that the block still owes us, oldest first.
  word_t pending_words [$];

  int unsigned mismatch_count;
  int unsigned cycle_count;

  // Control shared by the sender and the receiver. When calm is set nobody
  // idles; hold_off asks the receiver for one long stall.
  bit calm;
  bit hold_off;

  script_row_t script [SCRIPT_LEN];

  mersenne_twister_generator i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_half_width    (in_half_width),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_random_value (out_random_value),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_seed_value   (cfg_seed_value)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Fill all state words from the seed with the multiplier recurrence. The
  // arithmetic is 32 bits wide, so it wraps just like the hardware does.
  function automatic void refill_from_seed();
    twister_words[0] = seed_word;
    for (int k = 1; k < STATE_DEPTH; k++) begin
      twister_words[k] = MT_MULT * (twister_words[k-1] ^ (twister_words[k-1] >> 30))
                         + word_t'(k);
    end
  endfunction

  // Regenerate the whole state in place. Words beyond the wrap point read
  // far words that have already been updated, as the in-place order implies.
  function automatic void twist_state();
    word_t mixed;
    word_t fresh;
    int    next_k;
    int    far_k;
    for (int k = 0; k < STATE_DEPTH; k++) begin
      next_k = (k + 1) % STATE_DEPTH;
      far_k  = (k + TWIST_OFFSET) % STATE_DEPTH;
      mixed  = (twister_words[k] & WORD_TOP_BIT) | (twister_words[next_k] & WORD_LOW_BITS);
      fresh  = twister_words[far_k] ^ (mixed >> 1);
      if (mixed[0]) begin
        fresh ^= MT_MATRIX;
      end
      twister_words[k] = fresh;
    end
  endfunction

  // Predict the result of one draw and advance the state. An unseeded state
  // is filled and twisted first; an exhausted one is only twisted.
  function automatic word_t next_tempered_word(input logic half);
    word_t y;
    if (draw_pos >= STATE_DEPTH) begin
      if (draw_pos > STATE_DEPTH) begin
        refill_from_seed();
      end
      twist_state();
      draw_pos = 0;
    end
    y = twister_words[draw_pos];
    draw_pos++;
    y ^= y >> 11;
    y ^= (y << 7) & TEMPER_B;
    y ^= (y << 15) & TEMPER_C;
    y ^= y >> 18;
    return half ? (y >> 1) : y;
  endfunction

  // Offer one draw request and hold it until the transfer happens. Valid is
  // either kept high with a new payload or dropped for a burst, never both in
  // the same step. The expectation is queued at the edge of the transfer.
  task automatic issue_draw(input logic half, input logic known, input word_t value);
    int    gap;
    word_t predicted;
    gap = 0;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 11);
    end
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_half_width <= half;
    do @(posedge clk); while (!in_ready);
    predicted = next_tempered_word(half);
    pending_words.push_back(known ? value : predicted);
  endtask

  // Stop offering requests and wait until every owed word has arrived.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_words.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Write the seed register once the block is idle. The write only arms a
  // reseed; the block refills its state before taking the next request.
  task automatic write_seed(input word_t value);
    drain_results();
    @(negedge clk);
    cfg_valid      <= 1'b1;
    cfg_seed_value <= value;
    do @(posedge clk); while (!cfg_ready);
    seed_word = value;
    draw_pos  = UNSEEDED;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Receiver: ready drops in short random bursts, and once, on request, for a
  // long stretch while the sender keeps offering requests.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_off = 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 11) - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Result checker: every transfer must match the oldest owed word.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (pending_words.size() == 0) begin
        $display("%0t: random_value expected none, got %h", $time, out_random_value);
        mismatch_count++;
      end else begin
        if (out_random_value !== pending_words[0]) begin
          $display("%0t: random_value expected %h, got %h",
                   $time, pending_words[0], out_random_value);
          mismatch_count++;
        end
        void'(pending_words.pop_front());
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int unsigned phase_len;
    word_t       phase_seed;

    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_half_width  = 1'b0;
    cfg_valid      = 1'b0;
    cfg_seed_value = '0;
    mismatch_count = 0;
    cycle_count    = 0;
    calm           = 1'b0;
    hold_off       = 1'b0;
    seed_word      = SEED_RST;
    draw_pos       = UNSEEDED;
    for (int k = 0; k < STATE_DEPTH; k++) begin
      twister_words[k] = '0;
    end

    // Directed script. With the reset seed the first two words of the
    // standard sequence are well known; the rest go through the predictor.
    // Seed writes cover all zeros, all ones, a return to the reset seed and
    // two mixed patterns that toggle the top and bottom bits.
    script = '{
      '{1'b0, 32'h0000_0000, 1'b0, 1'b1, 32'hd091_bb5c},
      '{1'b0, 32'h0000_0000, 1'b1, 1'b1, 32'h1157_4f7b},
      '{1'b0, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
      '{1'b0, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
      '{1'b1, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
      '{1'b0, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
      '{1'b0, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
      '{1'b0, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
      '{1'b1, 32'hffff_ffff, 1'b0, 1'b0, 32'h0000_0000},
      '{1'b0, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
      '{1'b0, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
      '{1'b1, SEED_RST,      1'b0, 1'b0, 32'h0000_0000},
      '{1'b0, 32'h0000_0000, 1'b0, 1'b1, 32'hd091_bb5c},
      '{1'b0, 32'h0000_0000, 1'b1, 1'b1, 32'h1157_4f7b},
      '{1'b0, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
      '{1'b1, 32'h8000_0001, 1'b0, 1'b0, 32'h0000_0000},
      '{1'b0, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
      '{1'b0, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
      '{1'b1, 32'h7fff_fffe, 1'b0, 1'b0, 32'h0000_0000},
      '{1'b0, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
      '{1'b0, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000}
    };

    // Synchronous reset, released at a falling edge.
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < SCRIPT_LEN; r++) begin
      if (script[r].reseed) begin
        write_seed(script[r].seed);
      end else begin
        issue_draw(script[r].half, script[r].known, script[r].value);
      end
    end

    // Random phases. The first is long enough to pass a full twist of the
    // state. The third continues the stream of the second without a seed
    // write, so the sender simply pauses until every owed word is back, and
    // it also carries the long receiver stall. The last runs with no idling.
    for (int p = 0; p < 5; p++) begin
      phase_len = (p == 0) ? 660 : 60;
      case (p)
        0: phase_seed = $urandom;
        1: phase_seed = 32'h0000_0000;
        3: phase_seed = 32'hffff_ffff;
        default: phase_seed = $urandom;
      endcase
      if (p == 2) begin
        drain_results();
      end else begin
        write_seed(phase_seed);
      end
      if (p == 4) begin
        calm = 1'b1;
      end
      for (int i = 0; i < phase_len; i++) begin
        if (p == 2 && i == 10) begin
          hold_off = 1'b1;
        end
        issue_draw(logic'($urandom_range(0, 1)), 1'b0, '0);
      end
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && pending_words.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/mtg_pkg.sv
rtl/core/mtg_state_mem.sv
rtl/core/mtg_seeder.sv
rtl/core/mtg_out_skid.sv
rtl/core/mersenne_twister_generator.sv
bench/mersenne_twister_generator_tb.sv
